// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the class score accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/csa_pkg.sv =====
// Package with constants, types and codes of the class score accumulator.
package csa_pkg;

  localparam int NUM_CLASSES = 256;
  localparam int FRAC_BITS   = 16;
  localparam int SCORE_W     = 32;
  localparam int CLASS_W     = 8;
  localparam int IDX_W       = $clog2(NUM_CLASSES);
  // The total of all scores but class 0.
  localparam int TOT_W       = SCORE_W + IDX_W;
  // A normalized score never exceeds one, so the quotient needs FRAC_BITS + 1 bits.
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int CNT_W       = $clog2(QUO_W + 1);
  // Dividend is (score << FRAC_BITS) + total / 2.
  localparam int NUM_W       = (((SCORE_W + FRAC_BITS) > (TOT_W - 1)) ?
                                (SCORE_W + FRAC_BITS) : (TOT_W - 1)) + 1;
  localparam int PROD_W      = 2 * SCORE_W;

  localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << FRAC_BITS;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [QUO_W-1:0]   QUO_MAX   = QUO_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0]  RND_HALF  = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NUM_CLASSES - 1);

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [SCORE_W-1:0] score_t;

  typedef enum logic [2:0] {
    ACT_VOTE   = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_ADD    = 3'd2,
    ACT_MUL    = 3'd3,
    ACT_NORM   = 3'd4,
    ACT_QUERY  = 3'd5,
    ACT_CLEAR  = 3'd6
  } csa_action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_SUM = 2'd1,
    ST_SAT      = 2'd2
  } csa_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RMW_RD,
    S_RMW_EXEC,
    S_MUL_RND,
    S_SUM_RD,
    S_SUM_ACC,
    S_SUM_CHK,
    S_NRM_RD,
    S_NRM_CHK,
    S_NRM_DIV,
    S_Q_RD,
    S_Q_CMP,
    S_OUT
  } csa_state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [CLASS_W-1:0] class_id;
    logic [SCORE_W-1:0] value;
  } csa_in_t;

  typedef struct packed {
    logic [CLASS_W-1:0] max_class;
    logic [1:0]         status;
  } csa_out_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    score_t wdata;
    idx_t   raddr;
  } ram_req_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [TOT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/csa_score_ram.sv =====
// Score memory: one write port and one registered read port.
module csa_score_ram (
  input  logic              clk_i,
  input  csa_pkg::ram_req_t req_i,
  output csa_pkg::score_t   rdata_o
);

  csa_pkg::score_t mem [csa_pkg::NUM_CLASSES];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[req_i.raddr];
  end

endmodule

// ===== rtl/core/csa_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module csa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csa_pkg::div_req_t req_i,
  output csa_pkg::div_rsp_t rsp_o
);

  logic                      busy_q, busy_d;
  logic [csa_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [csa_pkg::TOT_W-1:0] rem_q, rem_d;
  logic [csa_pkg::TOT_W-1:0] den_q, den_d;
  logic [csa_pkg::QUO_W-1:0] quo_q, quo_d;
  logic [csa_pkg::TOT_W:0]   part_rem;
  logic [csa_pkg::TOT_W:0]   diff;
  logic                      fits;

  // One compare and subtract step; dividend bits leave quo_q at the top
  // while quotient bits enter at the bottom.
  assign part_rem = {rem_q, quo_q[csa_pkg::QUO_W-1]};
  assign diff     = part_rem - {1'b0, den_q};
  assign fits     = part_rem >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      // The upper dividend part is below the divisor, so only the low bits iterate.
      busy_d = 1'b1;
      cnt_d  = csa_pkg::CNT_W'(csa_pkg::QUO_W);
      rem_d  = csa_pkg::TOT_W'(req_i.dividend >> csa_pkg::QUO_W);
      quo_d  = req_i.dividend[csa_pkg::QUO_W-1:0];
      den_d  = req_i.divisor;
    end else if (busy_q && (cnt_q != '0)) begin
      cnt_d = cnt_q - csa_pkg::CNT_W'(1);
      rem_d = fits ? diff[csa_pkg::TOT_W-1:0] : part_rem[csa_pkg::TOT_W-1:0];
      quo_d = {quo_q[csa_pkg::QUO_W-2:0], fits};
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = busy_q && (cnt_q == '0);
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/core/class_score_accumulator.sv =====
// Top level of the class score accumulator: sequencer, score datapath and present bits.
//
//   Channel | Direction | Handshake           | Beat
//   in      | input     | in_valid_i, in_stall_o   | csa_in_t  (action, class_id, value)
//   out     | output    | out_valid_o, out_stall_i | csa_out_t (max_class, status)
//
// Vote, insert and add pass S_RMW_RD, S_RMW_EXEC and S_OUT; multiply on a present
// class adds S_MUL_RND; clear and unused actions go straight to S_OUT. The result
// beat is offered as the sequencer returns to S_IDLE. Query walks the score memory
// in S_Q_RD and S_Q_CMP per class. Normalize sums classes 1 and up in S_SUM_RD and
// S_SUM_ACC, checks in S_SUM_CHK, then steps each class through S_NRM_RD, S_NRM_CHK
// and, if present, S_NRM_DIV in the one-bit-per-cycle divider, then S_OUT.
// Reset clears the present bits at once; score memory needs no clearing pass.
// The input is stalled until the result sits in the output register, which may
// wait on out_stall_i while the next beat is already being worked on.
`include "assert_macros.svh"

module class_score_accumulator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csa_pkg::csa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csa_pkg::csa_out_t out_data_o
);

  csa_pkg::csa_state_e              state_q, state_d;
  csa_pkg::csa_action_e             act_q, act_d;
  csa_pkg::idx_t                    cid_q, cid_d;
  csa_pkg::score_t                  val_q, val_d;
  csa_pkg::idx_t                    idx_q, idx_d;
  logic [csa_pkg::TOT_W-1:0]        total_q, total_d;
  csa_pkg::score_t                  best_val_q, best_val_d;
  csa_pkg::idx_t                    best_idx_q, best_idx_d;
  logic [csa_pkg::PROD_W-1:0]       prod_q, prod_d;
  csa_pkg::csa_status_e             st_q, st_d;
  logic [csa_pkg::CLASS_W-1:0]      mc_q, mc_d;
  logic [csa_pkg::NUM_CLASSES-1:0]  present_q, present_d;
  logic                             out_vld_q, out_vld_d;
  csa_pkg::csa_out_t                out_q, out_d;

  csa_pkg::ram_req_t                ram_req;
  csa_pkg::score_t                  rdata;
  csa_pkg::div_req_t                div_req;
  csa_pkg::div_rsp_t                div_rsp;

  csa_pkg::csa_action_e             act_in;
  logic                             slot_ok;
  csa_pkg::score_t                  addend;
  logic [csa_pkg::SCORE_W:0]        add_sum;
  logic [csa_pkg::PROD_W-1:0]       rnd_sum;
  logic [csa_pkg::PROD_W-1:0]       rnd_sh;
  logic                             mul_sat;
  logic                             cid_present;
  logic                             idx_present;
  logic                             out_free;
  logic                             q_better;

  csa_score_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(rdata)
  );

  csa_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Decode of the incoming beat.
  assign act_in  = csa_pkg::csa_action_e'(in_data_i.action);
  assign slot_ok = 32'(in_data_i.class_id) < 32'(csa_pkg::NUM_CLASSES);

  // Saturating adder for vote and add.
  assign addend  = (act_q == csa_pkg::ACT_VOTE) ? csa_pkg::SCORE_ONE : val_q;
  assign add_sum = {1'b0, rdata} + {1'b0, addend};

  // Rounding and clamping of the registered product.
  assign rnd_sum = prod_q + csa_pkg::RND_HALF;
  assign rnd_sh  = rnd_sum >> csa_pkg::FRAC_BITS;
  assign mul_sat = |rnd_sh[csa_pkg::PROD_W-1:csa_pkg::SCORE_W];

  assign cid_present = present_q[cid_q];
  assign idx_present = present_q[idx_q];
  assign q_better    = idx_present && (rdata > best_val_q);

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != csa_pkg::S_IDLE);

  // Sequencer: next state, datapath registers and memory and divider requests.
  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    cid_d      = cid_q;
    val_d      = val_q;
    idx_d      = idx_q;
    total_d    = total_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    prod_d     = prod_q;
    st_d       = st_q;
    mc_d       = mc_q;
    present_d  = present_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;

    ram_req.we    = 1'b0;
    ram_req.waddr = (state_q == csa_pkg::S_NRM_DIV) ? idx_q : cid_q;
    ram_req.wdata = '0;
    ram_req.raddr = (state_q == csa_pkg::S_RMW_RD) ? cid_q : idx_q;

    div_req.start    = 1'b0;
    div_req.dividend = (csa_pkg::NUM_W'(rdata) << csa_pkg::FRAC_BITS) +
                       csa_pkg::NUM_W'(total_q >> 1);
    div_req.divisor  = total_q;

    case (state_q)
      csa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          act_d = act_in;
          cid_d = csa_pkg::IDX_W'(in_data_i.class_id);
          val_d = in_data_i.value;
          st_d  = csa_pkg::ST_OK;
          mc_d  = '0;
          if (act_in inside {csa_pkg::ACT_VOTE, csa_pkg::ACT_INSERT,
                             csa_pkg::ACT_ADD, csa_pkg::ACT_MUL}) begin
            state_d = slot_ok ? csa_pkg::S_RMW_RD : csa_pkg::S_OUT;
          end else if (act_in == csa_pkg::ACT_NORM) begin
            idx_d   = csa_pkg::IDX_W'(1);
            total_d = '0;
            state_d = csa_pkg::S_SUM_RD;
          end else if (act_in == csa_pkg::ACT_QUERY) begin
            idx_d      = '0;
            best_val_d = '0;
            best_idx_d = '0;
            state_d    = csa_pkg::S_Q_RD;
          end else if (act_in == csa_pkg::ACT_CLEAR) begin
            present_d = '0;
            state_d   = csa_pkg::S_OUT;
          end else begin
            state_d = csa_pkg::S_OUT;
          end
        end
      end

      csa_pkg::S_RMW_RD: begin
        state_d = csa_pkg::S_RMW_EXEC;
      end

      // Read data of the addressed class is valid here.
      csa_pkg::S_RMW_EXEC: begin
        state_d = csa_pkg::S_OUT;
        case (act_q)
          csa_pkg::ACT_VOTE, csa_pkg::ACT_ADD: begin
            ram_req.we        = 1'b1;
            present_d[cid_q]  = 1'b1;
            if (!cid_present) begin
              ram_req.wdata = addend;
            end else if (add_sum[csa_pkg::SCORE_W]) begin
              ram_req.wdata = csa_pkg::SCORE_MAX;
              st_d          = csa_pkg::ST_SAT;
            end else begin
              ram_req.wdata = add_sum[csa_pkg::SCORE_W-1:0];
            end
          end
          csa_pkg::ACT_INSERT: begin
            if (!cid_present) begin
              ram_req.we       = 1'b1;
              ram_req.wdata    = val_q;
              present_d[cid_q] = 1'b1;
            end
          end
          csa_pkg::ACT_MUL: begin
            present_d[cid_q] = 1'b1;
            if (cid_present) begin
              prod_d  = csa_pkg::PROD_W'(rdata) * csa_pkg::PROD_W'(val_q);
              state_d = csa_pkg::S_MUL_RND;
            end else begin
              ram_req.we    = 1'b1;
              ram_req.wdata = val_q;
            end
          end
          default: begin
          end
        endcase
      end

      csa_pkg::S_MUL_RND: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = mul_sat ? csa_pkg::SCORE_MAX : rnd_sh[csa_pkg::SCORE_W-1:0];
        if (mul_sat) begin
          st_d = csa_pkg::ST_SAT;
        end
        state_d = csa_pkg::S_OUT;
      end

      csa_pkg::S_SUM_RD: begin
        state_d = csa_pkg::S_SUM_ACC;
      end

      // Total of all present scores but class 0.
      csa_pkg::S_SUM_ACC: begin
        if (idx_present) begin
          total_d = total_q + csa_pkg::TOT_W'(rdata);
        end
        if (idx_q == csa_pkg::LAST_IDX) begin
          state_d = csa_pkg::S_SUM_CHK;
        end else begin
          idx_d   = idx_q + csa_pkg::IDX_W'(1);
          state_d = csa_pkg::S_SUM_RD;
        end
      end

      // A zero total leaves the table as it is, class 0 included.
      csa_pkg::S_SUM_CHK: begin
        if (total_q == '0) begin
          st_d    = csa_pkg::ST_ZERO_SUM;
          state_d = csa_pkg::S_OUT;
        end else begin
          present_d[0] = 1'b0;
          idx_d        = csa_pkg::IDX_W'(1);
          state_d      = csa_pkg::S_NRM_RD;
        end
      end

      csa_pkg::S_NRM_RD: begin
        state_d = csa_pkg::S_NRM_CHK;
      end

      csa_pkg::S_NRM_CHK: begin
        if (idx_present) begin
          div_req.start = 1'b1;
          state_d       = csa_pkg::S_NRM_DIV;
        end else if (idx_q == csa_pkg::LAST_IDX) begin
          state_d = csa_pkg::S_OUT;
        end else begin
          idx_d   = idx_q + csa_pkg::IDX_W'(1);
          state_d = csa_pkg::S_NRM_RD;
        end
      end

      // Write back the rounded quotient once the divider is done.
      csa_pkg::S_NRM_DIV: begin
        if (div_rsp.done) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = csa_pkg::SCORE_W'(div_rsp.quotient);
          if (idx_q == csa_pkg::LAST_IDX) begin
            state_d = csa_pkg::S_OUT;
          end else begin
            idx_d   = idx_q + csa_pkg::IDX_W'(1);
            state_d = csa_pkg::S_NRM_RD;
          end
        end
      end

      csa_pkg::S_Q_RD: begin
        state_d = csa_pkg::S_Q_CMP;
      end

      // Strict compare keeps the lowest class on ties.
      csa_pkg::S_Q_CMP: begin
        if (q_better) begin
          best_val_d = rdata;
          best_idx_d = idx_q;
        end
        if (idx_q == csa_pkg::LAST_IDX) begin
          mc_d    = csa_pkg::CLASS_W'(q_better ? idx_q : best_idx_q);
          state_d = csa_pkg::S_OUT;
        end else begin
          idx_d   = idx_q + csa_pkg::IDX_W'(1);
          state_d = csa_pkg::S_Q_RD;
        end
      end

      // Hand the result to the output register as soon as it is free.
      csa_pkg::S_OUT: begin
        if (out_free) begin
          out_vld_d       = 1'b1;
          out_d.max_class = mc_q;
          out_d.status    = st_q;
          state_d         = csa_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = csa_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= csa_pkg::S_IDLE;
      present_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    cid_q      <= cid_d;
    val_q      <= val_d;
    idx_q      <= idx_d;
    total_q    <= total_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    prod_q     <= prod_d;
    st_q       <= st_d;
    mc_q       <= mc_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks on the sequencer and divider.
  `CSA_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != csa_pkg::S_IDLE, "accepted beat did not start work")
  `CSA_ASSERT_NOW(a_quotient_bound, div_rsp.done, div_rsp.quotient <= csa_pkg::QUO_MAX, "normalized score above one")
  `CSA_ASSERT_NEXT(a_norm_drops_class0, (state_q == csa_pkg::S_SUM_CHK) && (total_q != '0), !present_q[0], "class 0 kept by normalize")

endmodule
